// File: hdl/adb_packet_receive_queue_top_assert.svh
// Assertion macros used by the receive queue sequencer (adbq_seq).
// Each macro expects clk and arst_n in scope.
`ifndef ADB_PACKET_RECEIVE_QUEUE_TOP_ASSERT_SVH
`define ADB_PACKET_RECEIVE_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication.
`define ADBQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("adbq: same-cycle check failed");

// Next-cycle implication.
`define ADBQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adbq: next-cycle check failed");

`endif

// File: hdl/adbq_pkg.sv
package adbq_pkg;

	localparam int unsigned RING_SLOTS_DEF = 8;
	localparam int unsigned MAX_REPLY_DEF  = 24;

	localparam int unsigned MODE_W      = 2;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned OUTCOME_W   = 3;
	localparam int unsigned DATA_IDX_W  = 5;
	localparam int unsigned MIN_PACKET  = 3;
	localparam logic [BYTE_W-1:0] PACKET_TYPE_DATA = 8'h00;

	typedef enum logic [MODE_W-1:0] {
		MODE_BYTE  = 2'd0,
		MODE_ABORT = 2'd1,
		MODE_POP   = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OC_QUEUED    = 3'd0,
		OC_IGNORED   = 3'd1,
		OC_DROPPED   = 3'd2,
		OC_PACKET    = 3'd3,
		OC_EMPTY     = 3'd4,
		OC_DISCARDED = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		PH_ATTN = 2'd0,
		PH_RECV = 2'd1,
		PH_OVER = 2'd2
	} rx_phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BYTE,
		S_JUDGE,
		S_POP,
		S_RD1,
		S_RD2,
		S_DATA
	} seq_state_t;

	typedef struct packed {
		logic byte_we;
		logic len_we;
	} store_ctl_t;

endpackage

// File: hdl/adbq_if.sv
interface adbq_item_if import adbq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [MODE_W-1:0]     mode;
	logic [BYTE_W-1:0]     link_byte;
	logic                  end_of_packet;

	modport source (output valid, mode, link_byte, end_of_packet, input ready);
	modport sink   (input valid, mode, link_byte, end_of_packet, output ready);
endinterface

interface adbq_result_if import adbq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OUTCOME_W-1:0]  outcome;
	logic [BYTE_W-1:0]     status_flags;
	logic [BYTE_W-1:0]     echoed_command;
	logic [BYTE_W-1:0]     data_byte;
	logic [DATA_IDX_W-1:0] data_index;
	logic                  has_data;
	logic                  last;

	modport source (output valid, outcome, status_flags, echoed_command, data_byte,
		data_index, has_data, last, input ready);
	modport sink   (input valid, outcome, status_flags, echoed_command, data_byte,
		data_index, has_data, last, output ready);
endinterface

// File: hdl/adbq_store.sv
module adbq_store import adbq_pkg::*; #(
	parameter int unsigned RING_SLOTS = RING_SLOTS_DEF,
	parameter int unsigned MAX_REPLY  = MAX_REPLY_DEF,
	localparam int unsigned PTR_W  = $clog2(RING_SLOTS),
	localparam int unsigned SLOT_W = MAX_REPLY - 1,
	localparam int unsigned OFF_W  = $clog2(SLOT_W),
	localparam int unsigned LEN_W  = $clog2(MAX_REPLY)
) (
	input  logic              clk,
	input  store_ctl_t        ctl,
	input  logic [PTR_W-1:0]  wr_slot,
	input  logic [OFF_W-1:0]  wr_off,
	input  logic [BYTE_W-1:0] wr_byte,
	input  logic [LEN_W-1:0]  len_wr,
	input  logic [PTR_W-1:0]  rd_slot,
	input  logic [OFF_W-1:0]  rd_off,
	output logic [BYTE_W-1:0] rd_byte,
	output logic [LEN_W-1:0]  rd_len
);

	localparam int unsigned BYTE_DEPTH = RING_SLOTS * (2 ** OFF_W);

	logic [BYTE_W-1:0] byte_mem [BYTE_DEPTH];
	logic [LEN_W-1:0]  len_mem  [RING_SLOTS];
	logic [BYTE_W-1:0] rd_byte_q;
	logic [LEN_W-1:0]  rd_len_q;

	// Slot bytes: row per ring slot, column per packet byte
	always_ff @(posedge clk) begin
		if (ctl.byte_we) begin
			byte_mem[{wr_slot, wr_off}] <= wr_byte;
		end
		rd_byte_q <= byte_mem[{rd_slot, rd_off}];
	end

	always_ff @(posedge clk) begin
		if (ctl.len_we) begin
			len_mem[wr_slot] <= len_wr;
		end
		rd_len_q <= len_mem[rd_slot];
	end

	assign rd_byte = rd_byte_q;
	assign rd_len  = rd_len_q;

endmodule

// File: hdl/adbq_seq.sv
`include "adb_packet_receive_queue_top_assert.svh"

module adbq_seq import adbq_pkg::*; #(
	parameter int unsigned RING_SLOTS = RING_SLOTS_DEF,
	parameter int unsigned MAX_REPLY  = MAX_REPLY_DEF,
	localparam int unsigned PTR_W  = $clog2(RING_SLOTS),
	localparam int unsigned SLOT_W = MAX_REPLY - 1,
	localparam int unsigned OFF_W  = $clog2(SLOT_W),
	localparam int unsigned LEN_W  = $clog2(MAX_REPLY)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              deliver_enable,
	adbq_item_if.sink         item,
	adbq_result_if.source     result,
	output store_ctl_t        store_ctl,
	output logic [PTR_W-1:0]  wr_slot,
	output logic [OFF_W-1:0]  wr_off,
	output logic [BYTE_W-1:0] wr_byte,
	output logic [LEN_W-1:0]  len_wr,
	output logic [PTR_W-1:0]  rd_slot,
	output logic [OFF_W-1:0]  rd_off,
	input  logic [BYTE_W-1:0] rd_byte,
	input  logic [LEN_W-1:0]  rd_len
);

	localparam int unsigned CNT_W = $clog2(MAX_REPLY + 1);

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
		return (i == PTR_W'(RING_SLOTS - 1)) ? '0 : i + PTR_W'(1);
	endfunction

	seq_state_t        state_q, state_d;
	rx_phase_t         phase_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] type_q;
	logic [PTR_W-1:0]  head_q, tail_q, slot_q;
	logic [BYTE_W-1:0] byte_q, st_q, cmd_q;
	logic              eop_q;
	logic [LEN_W-1:0]  nd_q, idx_q;

	logic                  res_valid_q;
	outcome_t              res_outcome_q;
	logic [BYTE_W-1:0]     res_status_q, res_cmd_q, res_data_q;
	logic [DATA_IDX_W-1:0] res_index_q;
	logic                  res_has_q, res_last_q;

	logic                  load_ok, res_load, empty, full, last_now, has_now;
	outcome_t              judge, res_outcome_d;
	logic [BYTE_W-1:0]     res_status_d, res_cmd_d, res_data_d;
	logic [DATA_IDX_W-1:0] res_index_d;
	logic                  res_has_d, res_last_d;
	logic [CNT_W-1:0]      cnt_inc;
	logic [LEN_W-1:0]      len_c, nd_calc;

	assign load_ok  = !res_valid_q || result.ready;
	assign empty    = (head_q == tail_q);
	assign full     = (ring_next(tail_q) == head_q);
	assign cnt_inc  = count_q + CNT_W'(1);
	assign has_now  = (nd_q != '0);
	assign last_now = !has_now || ((idx_q + LEN_W'(1)) == nd_q);

	always_comb begin
		if (count_q < CNT_W'(MIN_PACKET) || type_q != PACKET_TYPE_DATA) begin
			judge = OC_IGNORED;
		end else if (full) begin
			judge = OC_DROPPED;
		end else begin
			judge = OC_QUEUED;
		end
	end

	// Clamp stored length to the slot, then strip status and command
	always_comb begin
		if (rd_len > LEN_W'(SLOT_W)) begin
			len_c = LEN_W'(SLOT_W);
		end else if (rd_len < LEN_W'(2)) begin
			len_c = LEN_W'(2);
		end else begin
			len_c = rd_len;
		end
		nd_calc = len_c - LEN_W'(2);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					unique case (mode_t'(item.mode))
						MODE_BYTE:  state_d = S_BYTE;
						MODE_ABORT: state_d = S_JUDGE;
						MODE_POP:   state_d = S_POP;
						MODE_NOP:   state_d = S_IDLE;
					endcase
				end
			end
			S_BYTE:  state_d = eop_q ? S_JUDGE : S_IDLE;
			S_JUDGE: state_d = load_ok ? S_IDLE : S_JUDGE;
			S_POP: begin
				if (empty || !deliver_enable) begin
					state_d = load_ok ? S_IDLE : S_POP;
				end else begin
					state_d = S_RD1;
				end
			end
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_DATA;
			S_DATA:  state_d = (load_ok && last_now) ? S_IDLE : S_DATA;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		item.ready    = (state_q == S_IDLE);
		store_ctl     = '0;
		wr_slot       = tail_q;
		wr_off        = OFF_W'(count_q - CNT_W'(1));
		wr_byte       = byte_q;
		len_wr        = LEN_W'(count_q - CNT_W'(1));
		rd_slot       = slot_q;
		rd_off        = '0;
		res_load      = 1'b0;
		res_outcome_d = OC_IGNORED;
		res_status_d  = '0;
		res_cmd_d     = '0;
		res_data_d    = '0;
		res_index_d   = '0;
		res_has_d     = 1'b0;
		res_last_d    = 1'b1;
		unique case (state_q)
			S_IDLE: ;
			S_BYTE: begin
				store_ctl.byte_we = (phase_q == PH_RECV) && (count_q != '0);
			end
			S_JUDGE: begin
				res_load         = load_ok;
				res_outcome_d    = judge;
				store_ctl.len_we = load_ok && (judge == OC_QUEUED);
			end
			S_POP: begin
				rd_slot = head_q;
				if (empty) begin
					res_load      = load_ok;
					res_outcome_d = OC_EMPTY;
				end else if (!deliver_enable) begin
					res_load      = load_ok;
					res_outcome_d = OC_DISCARDED;
				end
			end
			S_RD1: rd_off = OFF_W'(1);
			S_RD2: rd_off = OFF_W'(2);
			S_DATA: begin
				// hold the read address while stalled, step it once the beat goes out
				rd_off        = load_ok ? OFF_W'(idx_q + LEN_W'(3)) : OFF_W'(idx_q + LEN_W'(2));
				res_load      = load_ok;
				res_outcome_d = OC_PACKET;
				res_status_d  = st_q;
				res_cmd_d     = cmd_q;
				res_data_d    = has_now ? rd_byte : '0;
				res_index_d   = has_now ? DATA_IDX_W'(idx_q) : '0;
				res_has_d     = has_now;
				res_last_d    = last_now;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_ATTN;
			count_q     <= '0;
			type_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_BYTE: begin
					case (phase_q)
						PH_RECV: begin
							if (count_q == '0) begin
								type_q <= byte_q;
							end
							count_q <= cnt_inc;
							if (cnt_inc >= CNT_W'(MAX_REPLY)) begin
								phase_q <= PH_OVER;
							end
						end
						PH_OVER: ;
						default: begin
							// attention byte: open the transfer, drop the byte
							phase_q <= PH_RECV;
							count_q <= '0;
						end
					endcase
				end
				S_JUDGE: begin
					if (load_ok) begin
						phase_q <= PH_ATTN;
						count_q <= '0;
						if (judge == OC_QUEUED) begin
							tail_q <= ring_next(tail_q);
						end
					end
				end
				S_POP: begin
					if (!empty && (deliver_enable || load_ok)) begin
						head_q <= ring_next(head_q);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			byte_q <= item.link_byte;
			eop_q  <= item.end_of_packet;
		end
		if (state_q == S_POP) begin
			slot_q <= head_q;
		end
		if (state_q == S_RD1) begin
			st_q <= rd_byte;
			nd_q <= nd_calc;
		end
		if (state_q == S_RD2) begin
			cmd_q <= rd_byte;
			idx_q <= '0;
		end
		if (state_q == S_DATA && load_ok) begin
			idx_q <= idx_q + LEN_W'(1);
		end
		if (res_load) begin
			res_outcome_q <= res_outcome_d;
			res_status_q  <= res_status_d;
			res_cmd_q     <= res_cmd_d;
			res_data_q    <= res_data_d;
			res_index_q   <= res_index_d;
			res_has_q     <= res_has_d;
			res_last_q    <= res_last_d;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.outcome        = res_outcome_q;
	assign result.status_flags   = res_status_q;
	assign result.echoed_command = res_cmd_q;
	assign result.data_byte      = res_data_q;
	assign result.data_index     = res_index_q;
	assign result.has_data       = res_has_q;
	assign result.last           = res_last_q;

	`ADBQ_ASSERT_IMPL(a_attn_count_zero, phase_q == PH_ATTN, count_q == '0)
	`ADBQ_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_REPLY))
	`ADBQ_ASSERT_IMPL(a_data_idx_range, state_q == S_DATA, nd_q == '0 || idx_q < nd_q)
	`ADBQ_ASSERT_NEXT(a_queued_advances, res_load && state_q == S_JUDGE && judge == OC_QUEUED, tail_q != $past(tail_q))

endmodule

// File: hdl/adb_packet_receive_queue_top.sv
// Byte item: handled in S_BYTE; with the end mark S_JUDGE then registers the verdict.
// Abort: verdict registered in S_JUDGE. Empty or discarded pop: result set in S_POP.
// Delivered pop: S_POP, S_RD1, S_RD2 read the slot, then S_DATA sends one data beat per
// cycle unless the result side stalls; the input is held until the last beat is loaded.
// Reset (arst_n low, asynchronous) empties the ring, closes any transfer and clears
// deliver_enable; slot memory contents are not cleared and need no clearing pass.
module adb_packet_receive_queue_top import adbq_pkg::*; #(
	parameter int unsigned RING_SLOTS = RING_SLOTS_DEF,
	parameter int unsigned MAX_REPLY  = MAX_REPLY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	adbq_item_if.sink     item,
	adbq_result_if.source result
);

	localparam int unsigned PTR_W  = $clog2(RING_SLOTS);
	localparam int unsigned SLOT_W = MAX_REPLY - 1;
	localparam int unsigned OFF_W  = $clog2(SLOT_W);
	localparam int unsigned LEN_W  = $clog2(MAX_REPLY);

	logic              deliver_enable_q;
	store_ctl_t        store_ctl;
	logic [PTR_W-1:0]  wr_slot, rd_slot;
	logic [OFF_W-1:0]  wr_off, rd_off;
	logic [BYTE_W-1:0] wr_byte, rd_byte;
	logic [LEN_W-1:0]  len_wr, rd_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_enable_q <= 1'b0;
		end else if (cfg_we) begin
			deliver_enable_q <= cfg_wdata;
		end
	end

	adbq_seq #(
		.RING_SLOTS (RING_SLOTS),
		.MAX_REPLY  (MAX_REPLY)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.deliver_enable (deliver_enable_q),
		.item           (item),
		.result         (result),
		.store_ctl      (store_ctl),
		.wr_slot        (wr_slot),
		.wr_off         (wr_off),
		.wr_byte        (wr_byte),
		.len_wr         (len_wr),
		.rd_slot        (rd_slot),
		.rd_off         (rd_off),
		.rd_byte        (rd_byte),
		.rd_len         (rd_len)
	);

	adbq_store #(
		.RING_SLOTS (RING_SLOTS),
		.MAX_REPLY  (MAX_REPLY)
	) u_store (
		.clk     (clk),
		.ctl     (store_ctl),
		.wr_slot (wr_slot),
		.wr_off  (wr_off),
		.wr_byte (wr_byte),
		.len_wr  (len_wr),
		.rd_slot (rd_slot),
		.rd_off  (rd_off),
		.rd_byte (rd_byte),
		.rd_len  (rd_len)
	);

endmodule

// File: sim/tb_adb_packet_receive_queue_top.sv
`timescale 1ns / 100ps

module tb_adb_packet_receive_queue_top;
	import adbq_pkg::*;

	localparam int unsigned SLOT_W       = MAX_REPLY_DEF - 1;
	localparam int unsigned RANDOM_ITEMS = 390;
	localparam int unsigned PHASES       = 6;

	typedef struct packed {
		logic [OUTCOME_W-1:0]  outcome;
		logic [BYTE_W-1:0]     status_flags;
		logic [BYTE_W-1:0]     echoed_command;
		logic [BYTE_W-1:0]     data_byte;
		logic [DATA_IDX_W-1:0] data_index;
		logic                  has_data;
		logic                  last;
	} reply_beat_t;

	class packet_ring_predictor;
		bit                deliver;
		rx_phase_t         phase;
		int unsigned       kept;
		logic [BYTE_W-1:0] ptype;
		logic [BYTE_W-1:0] slot_data [RING_SLOTS_DEF][SLOT_W];
		int unsigned       slot_len [RING_SLOTS_DEF];
		int unsigned       head;
		int unsigned       tail;
		reply_beat_t       owed_beats [$];
		int unsigned       mismatches;
		int unsigned       beats_seen;
		int unsigned       verdicts [8];

		function new();
			deliver    = 1'b0;
			phase      = PH_ATTN;
			kept       = 0;
			ptype      = '0;
			head       = 0;
			tail       = 0;
			mismatches = 0;
			beats_seen = 0;
			foreach (verdicts[i])
				verdicts[i] = 0;
		endfunction

		function void owe_verdict(outcome_t oc);
			owed_beats.push_back('{oc, 8'h00, 8'h00, 8'h00, 5'd0, 1'b0, 1'b1});
		endfunction

		// Judge the transfer that has just ended and close it.
		function outcome_t close_packet();
			int unsigned n;
			int unsigned nt;
			n     = kept;
			phase = PH_ATTN;
			kept  = 0;
			if (n < MIN_PACKET || ptype != PACKET_TYPE_DATA)
				return OC_IGNORED;
			nt = (tail + 1) % RING_SLOTS_DEF;
			if (nt == head)
				return OC_DROPPED;
			slot_len[tail] = n - 1;
			tail = nt;
			return OC_QUEUED;
		endfunction

		function void absorb_item(mode_t m, logic [BYTE_W-1:0] b, logic eop);
			int unsigned       h;
			int unsigned       nd;
			logic [BYTE_W-1:0] st;
			logic [BYTE_W-1:0] cmd;
			case (m)
			MODE_BYTE: begin
				if (phase == PH_RECV) begin
					if (kept == 0)
						ptype = b;
					else if (kept - 1 < SLOT_W)
						slot_data[tail][kept - 1] = b;
					kept++;
					if (kept >= MAX_REPLY_DEF)
						phase = PH_OVER;
				end else if (phase == PH_ATTN) begin
					// attention byte: open the transfer, drop the byte
					phase = PH_RECV;
					kept  = 0;
				end
				if (eop)
					owe_verdict(close_packet());
			end
			MODE_ABORT: begin
				owe_verdict(close_packet());
			end
			MODE_POP: begin
				if (head == tail) begin
					owe_verdict(OC_EMPTY);
				end else begin
					h    = head;
					head = (head + 1) % RING_SLOTS_DEF;
					if (!deliver) begin
						owe_verdict(OC_DISCARDED);
					end else begin
						st  = slot_data[h][0];
						cmd = slot_data[h][1];
						nd  = slot_len[h] - 2;
						if (nd == 0)
							owed_beats.push_back('{OC_PACKET, st, cmd, 8'h00, 5'd0, 1'b0, 1'b1});
						else
							for (int unsigned i = 0; i < nd; i++)
								owed_beats.push_back('{OC_PACKET, st, cmd, slot_data[h][i + 2],
									5'(i), 1'b1, (i + 1 == nd)});
					end
				end
			end
			default: begin
			end
			endcase
		endfunction

		task report(string what);
			$display("MISMATCH @%0t: %s", $time, what);
			mismatches++;
		endtask

		task check_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
			if (got !== want)
				report($sformatf("beat %0d %s: got %0h, expected %0h", beats_seen, name, got,
					want));
		endtask

		task check_result(reply_beat_t got);
			reply_beat_t want;
			beats_seen++;
			if (owed_beats.size() == 0) begin
				report($sformatf("beat %0d (outcome %0h) arrived with nothing outstanding",
					beats_seen, got.outcome));
				return;
			end
			want = owed_beats.pop_front();
			verdicts[want.outcome]++;
			check_field("outcome", got.outcome, want.outcome);
			check_field("status_flags", got.status_flags, want.status_flags);
			check_field("echoed_command", got.echoed_command, want.echoed_command);
			check_field("data_byte", got.data_byte, want.data_byte);
			check_field("data_index", got.data_index, want.data_index);
			check_field("has_data", got.has_data, want.has_data);
			check_field("last", got.last, want.last);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	adbq_item_if   item_ch ();
	adbq_result_if result_ch ();

	adb_packet_receive_queue_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	packet_ring_predictor ring_model;
	bit                   steady;
	int unsigned          items_sent;
	int unsigned          mode_count [4];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Call right after a rising edge; returns at the edge that takes the beat, or after a random idle gap that follows it.
	task automatic send_item(mode_t m, logic [BYTE_W-1:0] b, logic eop);
		int unsigned gap;
		item_ch.valid         <= 1'b1;
		item_ch.mode          <= m;
		item_ch.link_byte     <= b;
		item_ch.end_of_packet <= eop;
		do
			@(posedge clk);
		while (!item_ch.ready);
		ring_model.absorb_item(m, b, eop);
		items_sent++;
		mode_count[m]++;
		gap = pick_gap();
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_packet();
		int unsigned plen;
		int unsigned r;
		int unsigned ending;
		logic [BYTE_W-1:0] kind;
		send_item(MODE_BYTE, 8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
		if (ring_model.phase == PH_ATTN)
			return;
		kind = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : PACKET_TYPE_DATA;
		r = $urandom_range(0, 99);
		if (r < 8)
			plen = $urandom_range(0, 1);
		else if (r < 75)
			plen = $urandom_range(2, 8);
		else if (r < 93)
			plen = $urandom_range(9, 22);
		else
			plen = $urandom_range(23, 30);
		// 0: end mark on the last byte, 1: timeout abort, 2: leave the transfer open
		r = $urandom_range(0, 99);
		ending = (r < 85) ? 0 : (r < 95) ? 1 : 2;
		send_item(MODE_BYTE, kind, plen == 0 && ending == 0);
		for (int unsigned i = 0; i < plen; i++)
			send_item(MODE_BYTE, 8'($urandom_range(0, 255)), i + 1 == plen && ending == 0);
		if (ending == 1)
			send_item(MODE_ABORT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Drop valid, wait for every owed beat, then let the pipeline drain.
	task automatic settle();
		int unsigned waited;
		item_ch.valid <= 1'b0;
		waited = 0;
		while (ring_model.owed_beats.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (ring_model.owed_beats.size() != 0) begin
			ring_model.report($sformatf("%0d expected beats never arrived",
				ring_model.owed_beats.size()));
			ring_model.owed_beats.delete();
		end
		repeat (12) @(posedge clk);
	endtask

	task automatic set_delivery(bit en);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		ring_model.deliver = en;
	endtask

	initial begin : reply_sink
		int unsigned stall;
		stall = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				ring_model.check_result('{result_ch.outcome, result_ch.status_flags,
					result_ch.echoed_command, result_ch.data_byte, result_ch.data_index,
					result_ch.has_data, result_ch.last});
			if (stall > 0) begin
				stall--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin : stimulus
		int unsigned phase_no;
		int unsigned phase_end;
		int unsigned r;
		int unsigned pop_pct [PHASES];
		pop_pct = '{8, 30, 55, 25, 6, 45};
		ring_model = new();
		steady     = 1'b0;
		items_sent = 0;
		foreach (mode_count[i])
			mode_count[i] = 0;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= 1'b0;
		item_ch.valid         <= 1'b0;
		item_ch.mode          <= MODE_NOP;
		item_ch.link_byte     <= 8'h00;
		item_ch.end_of_packet <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// delivery off after reset: empty pop, idle abort, end mark on attention, no-op
		send_item(MODE_POP, 8'hFF, 1'b1);
		send_item(MODE_ABORT, 8'h00, 1'b0);
		send_item(MODE_BYTE, 8'hFF, 1'b1);
		send_item(MODE_NOP, 8'hA5, 1'b1);
		// two shortest packets; the first pop discards one
		send_item(MODE_BYTE, 8'h00, 1'b0);
		send_item(MODE_BYTE, PACKET_TYPE_DATA, 1'b0);
		send_item(MODE_BYTE, 8'h12, 1'b0);
		send_item(MODE_BYTE, 8'h34, 1'b1);
		send_item(MODE_BYTE, 8'hFF, 1'b0);
		send_item(MODE_BYTE, PACKET_TYPE_DATA, 1'b0);
		send_item(MODE_BYTE, 8'h7F, 1'b0);
		send_item(MODE_BYTE, 8'hFE, 1'b1);
		send_item(MODE_POP, 8'h00, 1'b0);
		set_delivery(1'b1);
		send_item(MODE_POP, 8'h00, 1'b0);
		send_item(MODE_BYTE, 8'h55, 1'b0);
		send_item(MODE_BYTE, PACKET_TYPE_DATA, 1'b0);
		send_item(MODE_BYTE, 8'hFF, 1'b0);
		send_item(MODE_BYTE, 8'h00, 1'b0);
		send_item(MODE_BYTE, 8'hA5, 1'b1);
		send_item(MODE_POP, 8'h00, 1'b0);
		// wrong packet type, cut short by a timeout abort
		send_item(MODE_BYTE, 8'hAA, 1'b0);
		send_item(MODE_BYTE, 8'h01, 1'b0);
		send_item(MODE_BYTE, 8'h03, 1'b0);
		send_item(MODE_BYTE, 8'h04, 1'b0);
		send_item(MODE_ABORT, 8'hFF, 1'b1);

		for (phase_no = 0; phase_no < PHASES; phase_no++) begin
			set_delivery(phase_no % 3 != 1);
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 39) == 0)
					steady = !steady;
				r = $urandom_range(0, 99);
				if (r < pop_pct[phase_no])
					send_item(MODE_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else if (r < pop_pct[phase_no] + 10)
					send_item(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				else
					send_random_packet();
			end
		end
		settle();

		$display("Sent %0d items: %0d bytes, %0d aborts, %0d pops, %0d no-ops; %s %0d beats.",
			items_sent, mode_count[MODE_BYTE], mode_count[MODE_ABORT], mode_count[MODE_POP],
			mode_count[MODE_NOP], "checked", ring_model.beats_seen);
		$display("Verdicts: %0d queued, %0d ignored, %0d dropped, %0d empty, %s",
			ring_model.verdicts[OC_QUEUED], ring_model.verdicts[OC_IGNORED],
			ring_model.verdicts[OC_DROPPED], ring_model.verdicts[OC_EMPTY],
			$sformatf("%0d discarded, %0d packet beats.",
				ring_model.verdicts[OC_DISCARDED], ring_model.verdicts[OC_PACKET]));
		if (ring_model.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// hard stop: end the run as failed if the stimulus has not finished
	initial begin : watchdog
		#14_400_000;
		$display("Verification failed");
		$finish;
	end

endmodule
